### rtl/rau_pkg.sv
package rau_pkg;

    localparam int OW = 16;          // operand width
    localparam int PW = 2 * OW + 1;  // magnitude width of products and sums
    localparam int RW = 32;          // result part width

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;
    localparam logic [2:0] OP_CMP = 3'd5;

    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_GT = 2'd1;
    localparam logic [1:0] CMP_LT = 2'd2;

    // Classified item handed from front to back
    typedef struct packed {
        logic [2:0]    op;
        logic          bad;   // a_den or b_den is zero
        logic          unused_op;
        logic          an_neg;
        logic [OW-1:0] an_mag;
        logic          ad_neg;
        logic [OW-1:0] ad_mag;
        logic          bn_neg;
        logic [OW-1:0] bn_mag;
        logic          bd_neg;
        logic [OW-1:0] bd_mag;
    } item_t;

    typedef struct packed {
        logic [RW-1:0] res_num;
        logic [RW-1:0] res_den;
        logic          status;
        logic [1:0]    cmp_result;
    } result_t;

    function automatic logic [OW:0] to_smag(input logic [OW-1:0] v);
        logic [OW-1:0] m;
        m = v[OW-1] ? (~v + OW'(1)) : v;
        return {v[OW-1], m};
    endfunction

endpackage

### rtl/rau_front.sv
module rau_front import rau_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [71:0]   s_tdata,
    output logic          q_valid,
    input  logic          q_ready,
    output item_t         q_item
);

    logic [OW:0] an_s, ad_s, bn_s, bd_s;
    logic [2:0]  op;
    item_t       item_next;
    item_t       mem_reg [2];
    logic [1:0]  wptr_reg, rptr_reg;
    logic        full, empty;

    // Split the packed transaction into sign and magnitude
    always_comb begin
        op   = s_tdata[2:0];
        an_s = to_smag(s_tdata[3 +: OW]);
        ad_s = to_smag(s_tdata[3+OW +: OW]);
        bn_s = to_smag(s_tdata[3+2*OW +: OW]);
        bd_s = to_smag(s_tdata[3+3*OW +: OW]);
        item_next.op        = op;
        item_next.unused_op = (op > OP_CMP);
        item_next.bad       = (ad_s[OW-1:0] == '0) || (bd_s[OW-1:0] == '0);
        item_next.an_neg = an_s[OW]; item_next.an_mag = an_s[OW-1:0];
        item_next.ad_neg = ad_s[OW]; item_next.ad_mag = ad_s[OW-1:0];
        item_next.bn_neg = bn_s[OW]; item_next.bn_mag = bn_s[OW-1:0];
        item_next.bd_neg = bd_s[OW]; item_next.bd_mag = bd_s[OW-1:0];
    end

    // Two-entry queue toward the back end
    assign full     = (wptr_reg[1] != rptr_reg[1]) && (wptr_reg[0] == rptr_reg[0]);
    assign empty    = (wptr_reg == rptr_reg);
    assign s_tready = !full;
    assign q_valid  = !empty;
    assign q_item   = mem_reg[rptr_reg[0]];

    always_ff @(posedge aclk) begin
        if (s_tvalid && !full) begin
            mem_reg[wptr_reg[0]] <= item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end else begin
            if (s_tvalid && !full) wptr_reg <= wptr_reg + 2'd1;
            if (q_ready && !empty) rptr_reg <= rptr_reg + 2'd1;
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        full |=> !(wptr_reg != $past(wptr_reg) && rptr_reg == $past(rptr_reg)))
        else $error("queue overflow");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (wptr_reg - rptr_reg) <= 2'd2) else $error("queue count out of range");
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |=> rptr_reg == $past(rptr_reg)) else $error("pop from empty queue");
`endif

endmodule

### rtl/rau_back.sv
module rau_back import rau_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  item_t    q_item,
    output logic     r_valid,
    input  logic     r_ready,
    output result_t  r_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P1   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_GCD  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam int CW = $clog2(PW + 1);
    localparam int NW = $clog2(2 * PW + 1);

    logic [2:0]    state_reg, state_next;
    item_t         it_reg;
    logic [PW-1:0] p1_reg, p2_reg, rd_reg;   // magnitudes
    logic          p1n_reg, p2n_reg, rdn_reg;
    logic [PW-1:0] rn_reg;
    logic          rnn_reg;
    logic [PW-1:0] gx_reg, gy_reg;
    logic [CW-1:0] sh_reg;
    logic [PW-1:0] qn_reg, qd_reg, rem_reg, dvsr_reg;
    logic [PW-1:0] src_d_reg;
    logic [NW-1:0] cnt_reg;
    result_t       out_reg;
    result_t       res_next;
    logic          out_valid_reg;

    logic [OW-1:0] ma, mb, mc, md;
    logic          sa, sb, sc, sd;
    logic [PW-1:0] sum_mag;
    logic          sum_neg, b_neg_eff;
    logic [PW-1:0] gdiff;
    logic [PW:0]   rem_sh;
    logic [PW-1:0] rem_sub;
    logic [PW-1:0] g_full;

    assign q_ready = (state_reg == ST_IDLE);
    assign r_valid = out_valid_reg;
    assign r_data  = out_reg;

    // Select multiplier operands per operation: p1 = ma*mb, p2 = mc*md
    always_comb begin
        ma = q_item.an_mag; sa = q_item.an_neg;
        mb = q_item.bd_mag; sb = q_item.bd_neg;
        mc = q_item.bn_mag; sc = q_item.bn_neg;
        md = q_item.ad_mag; sd = q_item.ad_neg;
        case (q_item.op)
            OP_MUL: begin
                mb = q_item.bn_mag; sb = q_item.bn_neg;
                mc = q_item.ad_mag; sc = q_item.ad_neg;
                md = q_item.bd_mag; sd = q_item.bd_neg;
            end
            OP_NEG: begin
                mb = OW'(1); sb = 1'b1;
                mc = q_item.ad_mag; sc = q_item.ad_neg;
                md = OW'(1); sd = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Signed-magnitude add of p1 and (optionally negated) p2
    always_comb begin
        b_neg_eff = p2n_reg ^ ((it_reg.op == OP_SUB) || (it_reg.op == OP_CMP));
        if (p1n_reg == b_neg_eff) begin
            sum_mag = p1_reg + p2_reg;
            sum_neg = p1n_reg;
        end else if (p1_reg >= p2_reg) begin
            sum_mag = p1_reg - p2_reg;
            sum_neg = p1n_reg;
        end else begin
            sum_mag = p2_reg - p1_reg;
            sum_neg = b_neg_eff;
        end
        if (sum_mag == '0) sum_neg = 1'b0;
    end

    always_comb begin
        gdiff   = (gx_reg >= gy_reg) ? (gx_reg - gy_reg) : (gy_reg - gx_reg);
        rem_sh  = {rem_reg, qn_reg[PW-1]};
        rem_sub = rem_sh[PW-1:0] - dvsr_reg;
        g_full  = gx_reg << sh_reg;
    end

    // Assemble the result transaction
    always_comb begin
        res_next = '0;
        if (!it_reg.unused_op) begin
            if (it_reg.bad || rd_reg == '0) begin
                res_next.status = 1'b1;
            end else if (it_reg.op == OP_CMP) begin
                res_next.cmp_result = (rn_reg == '0) ? CMP_EQ :
                    ((rnn_reg != (it_reg.ad_neg ^ it_reg.bd_neg)) ? CMP_LT : CMP_GT);
            end else begin
                res_next.res_num = rnn_reg ? RW'(~qd_reg + PW'(1)) : RW'(qd_reg);
                res_next.res_den = rdn_reg ? RW'(~qn_reg + PW'(1)) : RW'(qn_reg);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_P1;
            ST_P1:   state_next = (it_reg.bad || it_reg.unused_op || rd_reg == '0) ? ST_OUT
                                                                                  : ST_SUM;
            ST_SUM:  state_next = ST_GCD;
            ST_GCD:  if (gy_reg == '0 || gx_reg == gy_reg) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == NW'(2 * PW)) state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || r_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_valid_reg || r_ready)) out_valid_reg <= 1'b1;
            else if (r_ready) out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                it_reg  <= q_item;
                p1_reg  <= PW'(ma) * PW'(mb);
                p1n_reg <= sa ^ sb;
                p2_reg  <= PW'(mc) * PW'(md);
                p2n_reg <= sc ^ sd;
                // denominator product: ad*bd, or ad*bn for divide
                rd_reg  <= PW'(q_item.ad_mag) * PW'((q_item.op == OP_DIV) ? q_item.bn_mag
                                                                          : q_item.bd_mag);
                rdn_reg <= q_item.ad_neg ^ ((q_item.op == OP_DIV) ? q_item.bn_neg
                                                                 : q_item.bd_neg);
            end
            ST_P1: begin
                if (it_reg.op == OP_NEG) begin
                    rd_reg  <= PW'(it_reg.ad_mag);
                    rdn_reg <= it_reg.ad_neg;
                end
                if (it_reg.op == OP_MUL || it_reg.op == OP_DIV || it_reg.op == OP_NEG) begin
                    p2_reg <= '0;
                end
            end
            ST_SUM: begin
                rn_reg  <= sum_mag;
                rnn_reg <= (rd_reg == '0) ? 1'b0 : sum_neg;
                gx_reg  <= (sum_mag == '0) ? rd_reg : sum_mag;
                gy_reg  <= (sum_mag == '0) ? '0 : rd_reg;
                sh_reg  <= '0;
            end
            ST_GCD: begin
                // binary GCD: strip shared twos, then subtract-and-halve
                if (gy_reg == '0 || gx_reg == gy_reg) begin
                    src_d_reg <= rd_reg;
                    dvsr_reg  <= g_full;
                    qn_reg    <= rn_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                end else if (!gx_reg[0] && !gy_reg[0]) begin
                    gx_reg <= gx_reg >> 1;
                    gy_reg <= gy_reg >> 1;
                    sh_reg <= sh_reg + CW'(1);
                end else if (!gx_reg[0]) begin
                    gx_reg <= gx_reg >> 1;
                end else if (!gy_reg[0]) begin
                    gy_reg <= gy_reg >> 1;
                end else begin
                    gx_reg <= (gx_reg < gy_reg) ? gx_reg : gy_reg;
                    gy_reg <= gdiff >> 1;
                end
            end
            ST_DIV: begin
                // restoring division, numerator then denominator
                cnt_reg <= cnt_reg + NW'(1);
                if (cnt_reg == NW'(PW - 1)) begin
                    qd_reg <= {qn_reg[PW-2:0],
                               (rem_sh[PW] || rem_sh[PW-1:0] >= dvsr_reg)};
                    qn_reg <= src_d_reg;
                    rem_reg <= '0;
                end else if (cnt_reg != NW'(2 * PW)) begin
                    if (rem_sh[PW] || rem_sh[PW-1:0] >= dvsr_reg) begin
                        rem_reg <= rem_sub;
                        qn_reg  <= {qn_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[PW-1:0];
                        qn_reg  <= {qn_reg[PW-2:0], 1'b0};
                    end
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || r_ready) begin
                    out_reg <= res_next;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (r_valid && !r_ready) |=> $stable(r_data)) else $error("result changed under stall");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> state_reg == ST_IDLE) else $error("busy back end took item");
    a_gcd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> dvsr_reg != '0) else $error("zero divisor");
`endif

endmodule

### rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: combines or compares two signed 16-bit fractions and
// returns a result reduced to lowest terms or a comparison result.
// Input channel s_*: one transaction carries op and the four operand fields.
// Result channel m_*: one transaction per input, in order.
// An item goes through a two-entry queue into the execution unit, which
// forms the cross products with 16x16 multipliers, adds them, finds the GCD
// with a binary subtract-and-shift loop, then divides numerator and
// denominator by it with a one-bit-per-cycle divider. Compare items take the
// same path. Zero-denominator, division-by-zero and unused-code items skip
// the GCD and divider. One item is executed at a time; the front queue
// keeps accepting while the unit is busy.
// aresetn (synchronous, active low) empties the queue and drops any item in
// flight. When m_tready is low the finished result is held in the output
// register; the unit computes the next item and then waits; the queue fills.
module rational_arithmetic_unit_top import rau_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op[2:0], a_num, a_den, b_num, b_den, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // res_num, res_den, status, cmp_result, zero pad
);

    logic    q_valid, q_ready;
    item_t   q_item;
    result_t r_data;

    rau_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    rau_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r_data)
    );

    assign m_tdata = {5'd0, r_data.cmp_result, r_data.status,
                      r_data.res_den, r_data.res_num};

endmodule

### dv/testbench.sv
module testbench;
    import rau_pkg::*;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] a_num;
        logic [15:0] a_den;
        logic [15:0] b_num;
        logic [15:0] b_den;
    } frac_req_t;

    typedef struct packed {
        logic [31:0] res_num;
        logic [31:0] res_den;
        logic        status;
        logic [1:0]  cmp_result;
    } frac_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    frac_req_t pending_reqs[$];
    frac_res_t expected_results[$];
    int        error_count;
    int        results_seen;
    int        cycle_count;
    bit        stim_done;
    bit        calm_phase;
    bit        in_acc;
    int        src_gap;
    int        sink_gap;
    int        op_hits[8];

    localparam int CYCLE_LIMIT = 1000000;

    rational_arithmetic_unit_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock and reset
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Exact euclidean GCD on magnitudes
    function automatic logic [63:0] gcd_mag(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduced fraction for one request, using signed 64-bit arithmetic
    function automatic frac_res_t reduce_fraction(input frac_req_t req);
        frac_res_t r;
        longint an, ad, bn, bd, rn, rd, diff;
        logic [63:0] mn, md, g;
        bit flip;
        r = '0;
        an = longint'($signed(req.a_num));
        ad = longint'($signed(req.a_den));
        bn = longint'($signed(req.b_num));
        bd = longint'($signed(req.b_den));
        if (req.op > OP_CMP) return r;
        if (ad == 0 || bd == 0) begin
            r.status = 1'b1;
            return r;
        end
        if (req.op == OP_CMP) begin
            diff = an * bd - bn * ad;
            flip = (ad < 0) != (bd < 0);
            if (diff == 0) r.cmp_result = CMP_EQ;
            else if ((diff < 0) != flip) r.cmp_result = CMP_LT;
            else r.cmp_result = CMP_GT;
            return r;
        end
        case (req.op)
            OP_ADD: begin rn = an * bd + bn * ad; rd = ad * bd; end
            OP_SUB: begin rn = an * bd - bn * ad; rd = ad * bd; end
            OP_MUL: begin rn = an * bn; rd = ad * bd; end
            OP_DIV: begin rn = an * bd; rd = ad * bn; end
            default: begin rn = -an; rd = ad; end
        endcase
        if (rd == 0) begin
            r.status = 1'b1;
            return r;
        end
        mn = (rn < 0) ? -rn : rn;
        md = (rd < 0) ? -rd : rd;
        g = gcd_mag(mn, md);
        rn = rn / longint'(g);
        rd = rd / longint'(g);
        r.res_num = rn[31:0];
        r.res_den = rd[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
        error_count++;
    endtask

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 20)) - 10);
            4: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_req(input logic [2:0] op, input logic [15:0] an,
                             input logic [15:0] ad, input logic [15:0] bn,
                             input logic [15:0] bd);
        frac_req_t q;
        q.op = op; q.a_num = an; q.a_den = ad; q.b_num = bn; q.b_den = bd;
        pending_reqs.push_back(q);
    endtask

    // Stimulus: directed corners, then random traffic
    initial begin
        frac_req_t q;
        stim_done = 0;
        calm_phase = 0;
        queue_req(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        queue_req(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        queue_req(OP_SUB, 16'd1, 16'hfffe, 16'd1, 16'd2);
        queue_req(OP_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        queue_req(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_req(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
        queue_req(OP_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        queue_req(OP_NEG, 16'd6, 16'hfffc, 16'd0, 16'd1);
        queue_req(OP_NEG, 16'h8000, 16'd1, 16'd1, 16'd1);
        queue_req(OP_CMP, 16'd1, 16'd2, 16'd2, 16'd4);
        queue_req(OP_CMP, 16'd1, 16'hfffe, 16'd1, 16'd3);
        queue_req(OP_CMP, 16'd1, 16'd2, 16'd1, 16'd3);
        queue_req(OP_CMP, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        queue_req(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
        queue_req(OP_CMP, 16'd1, 16'd1, 16'd1, 16'd0);
        queue_req(OP_NEG, 16'd5, 16'd0, 16'd1, 16'd1);
        queue_req(OP_ADD, 16'd0, 16'hffff, 16'd0, 16'd1);
        queue_req(OP_MUL, 16'd0, 16'd7, 16'd9, 16'hfff9);
        queue_req(3'd6, 16'd1, 16'd1, 16'd1, 16'd1);
        queue_req(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        queue_req(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        queue_req(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        queue_req(OP_DIV, 16'd0, 16'd3, 16'd0, 16'd5);
        for (int i = 0; i < 1200; i++) begin
            q.op = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            q.a_num = pick_operand();
            q.b_num = pick_operand();
            q.a_den = pick_operand();
            q.b_den = pick_operand();
            // keep most denominators nonzero so arithmetic dominates
            if (q.a_den == 0 && $urandom_range(0, 3) != 0) q.a_den = 16'd1;
            if (q.b_den == 0 && $urandom_range(0, 3) != 0) q.b_den = 16'hffff;
            pending_reqs.push_back(q);
        end
        stim_done = 1;
    end

    // Record input transactions at the rising edge
    always @(posedge aclk) begin
        in_acc <= aresetn && s_tvalid && s_tready;
    end

    // Driver: present transactions at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  <= 0;
        end else begin
            calm_phase <= stim_done && pending_reqs.size() < 150;
            if (in_acc) begin
                frac_req_t q;
                q = pending_reqs.pop_front();
                expected_results.push_back(reduce_fraction(q));
                op_hits[q.op]++;
            end
            if (s_tvalid && !in_acc) begin
                // hold the waiting transaction
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !calm_phase
                         && $urandom_range(0, 19) == 0) begin
                src_gap <= $urandom_range(1, 15);
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {8'h00, pending_reqs[0].b_den, pending_reqs[0].b_num,
                             pending_reqs[0].a_den, pending_reqs[0].a_num,
                             pending_reqs[0].op};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            sink_gap <= $urandom_range(1, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            frac_res_t got, want;
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[64], m_tdata[66:65]};
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected res_num", m_tdata[31:0], 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (got.res_num !== want.res_num)
                    report_mismatch("res_num", got.res_num, want.res_num);
                if (got.res_den !== want.res_den)
                    report_mismatch("res_den", got.res_den, want.res_den);
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.cmp_result !== want.cmp_result)
                    report_mismatch("cmp_result", 32'(got.cmp_result),
                                    32'(want.cmp_result));
                if (m_tdata[71:67] !== '0)
                    report_mismatch("pad", 32'(m_tdata[71:67]), 32'd0);
            end
            results_seen++;
        end
    end

    // End of run and timeout
    initial begin
        error_count = 0;
        results_seen = 0;
        cycle_count = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        fork
            begin
                wait (stim_done);
                while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
                    @(posedge aclk);
                repeat (300) @(posedge aclk);
                $display("checked %0d results: add %0d sub %0d mul %0d div %0d neg %0d",
                         results_seen, op_hits[0], op_hits[1], op_hits[2], op_hits[3],
                         op_hits[4]);
                $display("compare %0d, unused codes %0d", op_hits[5],
                         op_hits[6] + op_hits[7]);
                if (error_count == 0)
                    $display("rational_arithmetic_unit_top: match");
                else
                    $display("rational_arithmetic_unit_top: mismatch");
                $finish;
            end
            begin
                while (cycle_count < CYCLE_LIMIT) begin
                    @(posedge aclk);
                    cycle_count++;
                end
                $display("timeout after %0d cycles", cycle_count);
                $display("rational_arithmetic_unit_top: mismatch");
                $finish;
            end
        join
    end

endmodule
